// ===== src/pst_pkg.sv =====
// Package for the parabolic stop-and-reverse tracker.
// Holds the price and factor widths, the payload and configuration types,
// the phase encoding and the register map. Depends on nothing.
`default_nettype none

package pst_pkg;

    localparam int PRICE_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = PRICE_BITS + FRAC_BITS;

    localparam int DATA_BITS    = 32;
    localparam int ADDR_BITS    = 3;
    localparam int REG_IDX_LSB  = 2;

    localparam logic [PRICE_BITS-1:0] PRICE_MAX      = '1;
    localparam logic [FRAC_BITS-1:0]  AF_STEP_RESET  = FRAC_BITS'(1311);
    localparam logic [FRAC_BITS-1:0]  AF_LIMIT_RESET = FRAC_BITS'(13107);

    typedef enum logic
    {
        REG_AF_STEP  = 1'b0,
        REG_AF_LIMIT = 1'b1
    } reg_index_t;

    typedef enum logic [1:0]
    {
        PHASE_FIRST = 2'd0,
        PHASE_SCAN  = 2'd1,
        PHASE_TREND = 2'd2
    } phase_t;

    typedef struct packed
    {
        logic [FRAC_BITS-1:0] af_step;
        logic [FRAC_BITS-1:0] af_limit;
    } cfg_t;

    typedef struct packed
    {
        logic [PRICE_BITS-1:0] bar_high;
        logic [PRICE_BITS-1:0] bar_low;
        logic                  restart;
    } bar_t;

    typedef struct packed
    {
        logic [PRICE_BITS-1:0] sar_level;
        logic                  level_valid;
        logic                  going_long;
    } level_t;

endpackage

`default_nettype wire

// ===== src/pst_bar_if.sv =====
// Input channel carrying one price bar per transfer.
// Depends on pst_pkg for the price width.
`default_nettype none

interface pst_bar_if;
    import pst_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] bar_high;
    logic [PRICE_BITS-1:0] bar_low;
    logic                  restart;

    modport source (output valid, output bar_high, output bar_low, output restart,
                    input ready);
    modport sink (input valid, input bar_high, input bar_low, input restart,
                  output ready);
endinterface

`default_nettype wire

// ===== src/pst_level_if.sv =====
// Output channel carrying one stop-and-reverse result per transfer.
// Depends on pst_pkg for the price width.
`default_nettype none

interface pst_level_if;
    import pst_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] sar_level;
    logic                  level_valid;
    logic                  going_long;

    modport source (output valid, output sar_level, output level_valid,
                    output going_long, input ready);
    modport sink (input valid, input sar_level, input level_valid,
                  input going_long, output ready);
endinterface

`default_nettype wire

// ===== src/pst_regs.sv =====
// APB-style configuration registers: acceleration step and limit.
// Depends on pst_pkg for the register map and the configuration type.
`default_nettype none

module pst_regs
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pst_pkg::ADDR_BITS-1:0]  paddr,
    input  wire logic [pst_pkg::DATA_BITS-1:0]  pwdata,
    output logic      [pst_pkg::DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output pst_pkg::cfg_t                       cfg
);
    import pst_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       write_en;

    assign pready   = 1'b1;
    assign index    = reg_index_t'(paddr[REG_IDX_LSB]);
    assign write_en = psel && penable && pwrite;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (index)
                REG_AF_STEP:  cfg_next.af_step  = pwdata[FRAC_BITS-1:0];
                REG_AF_LIMIT: cfg_next.af_limit = pwdata[FRAC_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_AF_STEP:  prdata = {{(DATA_BITS-FRAC_BITS){1'b0}}, cfg_reg.af_step};
            REG_AF_LIMIT: prdata = {{(DATA_BITS-FRAC_BITS){1'b0}}, cfg_reg.af_limit};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.af_step  <= AF_STEP_RESET;
            cfg_reg.af_limit <= AF_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/pst_core.sv =====
// Tracker state and the combinational update for one bar: scan for direction,
// parabolic step with clamping, and reversal. Depends on pst_pkg.
`default_nettype none

module pst_core
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire pst_pkg::cfg_t   cfg,
    input  wire logic   fire,
    input  wire pst_pkg::bar_t   item,
    output pst_pkg::level_t result
);
    import pst_pkg::*;

    phase_t                phase_reg, phase_next, e_phase;
    logic                  trend_reg, trend_next, e_trend;
    logic [FRAC_BITS-1:0]  accel_reg, accel_next, e_accel;
    logic [PRICE_BITS-1:0] ep_reg, ep_next, e_ep;
    logic [PRICE_BITS-1:0] th_reg, th_next, e_th;
    logic [PRICE_BITS-1:0] tl_reg, tl_next, e_tl;
    logic [PRICE_BITS-1:0] prior_reg, prior_next, e_prior;
    logic [PRICE_BITS-1:0] ph0_reg, ph0_next, e_ph0;
    logic [PRICE_BITS-1:0] ph1_reg, ph1_next, e_ph1;
    logic [PRICE_BITS-1:0] pl0_reg, pl0_next, e_pl0;
    logic [PRICE_BITS-1:0] pl1_reg, pl1_next, e_pl1;

    logic [PRICE_BITS-1:0] hi, lo;
    logic                  dir_up, dir_dn;
    logic                  ep_ge;
    logic [PRICE_BITS-1:0] span;
    logic [PROD_BITS-1:0]  prod;
    logic [PRICE_BITS-1:0] quot;
    logic                  ceil_bit;
    logic [PRICE_BITS-1:0] sar_raw;
    logic [PRICE_BITS-1:0] clamp_a, clamp_b;
    logic                  new_ext;
    logic [FRAC_BITS:0]    accel_sum;
    logic                  grow;
    logic                  reversal;
    logic [PRICE_BITS-1:0] lvl;
    logic                  lvl_valid;

    assign hi = item.bar_high;
    assign lo = item.bar_low;

    // A restart bar sees the state as it stands after reset.
    always_comb
    begin
        if (item.restart)
        begin
            e_phase = PHASE_FIRST;
            e_trend = 1'b1;
            e_accel = '0;
            e_ep    = '0;
            e_th    = '0;
            e_tl    = PRICE_MAX;
            e_prior = '0;
            e_ph0   = '0;
            e_ph1   = '0;
            e_pl0   = '0;
            e_pl1   = '0;
        end
        else
        begin
            e_phase = phase_reg;
            e_trend = trend_reg;
            e_accel = accel_reg;
            e_ep    = ep_reg;
            e_th    = th_reg;
            e_tl    = tl_reg;
            e_prior = prior_reg;
            e_ph0   = ph0_reg;
            e_ph1   = ph1_reg;
            e_pl0   = pl0_reg;
            e_pl1   = pl1_reg;
        end
    end

    assign dir_up = (hi > e_ph0) && (lo > e_pl0);
    assign dir_dn = (hi < e_ph0) && (lo < e_pl0);

    always_comb
    begin
        unique case (e_phase)
            PHASE_FIRST: phase_next = PHASE_SCAN;
            PHASE_SCAN:  phase_next = (dir_up || dir_dn) ? PHASE_TREND : PHASE_SCAN;
            PHASE_TREND: phase_next = PHASE_TREND;
            default:     phase_next = PHASE_FIRST;
        endcase
    end

    // Parabolic step: the level moves toward the extreme point by accel.
    assign ep_ge    = e_ep >= e_prior;
    assign span     = ep_ge ? (e_ep - e_prior) : (e_prior - e_ep);
    assign prod     = {{FRAC_BITS{1'b0}}, span} * {{PRICE_BITS{1'b0}}, e_accel};
    assign quot     = prod[PROD_BITS-1:FRAC_BITS];
    assign ceil_bit = |prod[FRAC_BITS-1:0];
    assign sar_raw  = ep_ge ? (e_prior + quot)
                            : (e_prior - quot - {{(PRICE_BITS-1){1'b0}}, ceil_bit});

    always_comb
    begin
        if (e_trend)
        begin
            clamp_a = (sar_raw > e_pl0) ? e_pl0 : sar_raw;
            clamp_b = (clamp_a > e_pl1) ? e_pl1 : clamp_a;
            new_ext = e_ep < hi;
            reversal = (lo < e_prior) || (clamp_b > lo);
        end
        else
        begin
            clamp_a = (sar_raw < e_ph0) ? e_ph0 : sar_raw;
            clamp_b = (clamp_a < e_ph1) ? e_ph1 : clamp_a;
            new_ext = e_ep > lo;
            reversal = (hi > e_prior) || (clamp_b < hi);
        end
    end

    assign accel_sum = {1'b0, e_accel} + {1'b0, cfg.af_step};
    assign grow      = new_ext && (accel_sum <= {1'b0, cfg.af_limit});

    always_comb
    begin
        trend_next = e_trend;
        accel_next = e_accel;
        ep_next    = e_ep;
        th_next    = e_th;
        tl_next    = e_tl;
        prior_next = e_prior;
        lvl        = '0;
        lvl_valid  = 1'b0;
        unique case (e_phase)
            PHASE_FIRST:
            begin
                lvl_valid = 1'b0;
            end
            PHASE_SCAN:
            begin
                tl_next = (lo < e_tl) ? lo : e_tl;
                th_next = (hi > e_th) ? hi : e_th;
                if (dir_up)
                begin
                    trend_next = 1'b1;
                    lvl        = e_pl0;
                    ep_next    = hi;
                end
                else if (dir_dn)
                begin
                    trend_next = 1'b0;
                    lvl        = e_ph0;
                    ep_next    = lo;
                end
                if (dir_up || dir_dn)
                begin
                    accel_next = cfg.af_step;
                    prior_next = lvl;
                    lvl_valid  = 1'b1;
                end
            end
            PHASE_TREND:
            begin
                if (reversal)
                begin
                    accel_next = cfg.af_step;
                    trend_next = !e_trend;
                    if (e_trend)
                    begin
                        ep_next = lo;
                        tl_next = lo;
                        lvl     = e_th;
                    end
                    else
                    begin
                        ep_next = hi;
                        th_next = hi;
                        lvl     = e_tl;
                    end
                end
                else
                begin
                    lvl = clamp_b;
                    if (grow)
                    begin
                        accel_next = accel_sum[FRAC_BITS-1:0];
                    end
                    if (new_ext)
                    begin
                        if (e_trend)
                        begin
                            th_next = hi;
                            ep_next = hi;
                        end
                        else
                        begin
                            tl_next = lo;
                            ep_next = lo;
                        end
                    end
                end
                prior_next = lvl;
                lvl_valid  = 1'b1;
            end
            default:
            begin
                lvl_valid = 1'b0;
            end
        endcase
    end

    assign ph1_next = e_ph0;
    assign pl1_next = e_pl0;
    assign ph0_next = hi;
    assign pl0_next = lo;

    assign result.sar_level   = lvl;
    assign result.level_valid = lvl_valid;
    assign result.going_long  = trend_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_FIRST;
            trend_reg <= 1'b1;
            accel_reg <= '0;
            ep_reg    <= '0;
            th_reg    <= '0;
            tl_reg    <= PRICE_MAX;
            prior_reg <= '0;
            ph0_reg   <= '0;
            ph1_reg   <= '0;
            pl0_reg   <= '0;
            pl1_reg   <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            trend_reg <= trend_next;
            accel_reg <= accel_next;
            ep_reg    <= ep_next;
            th_reg    <= th_next;
            tl_reg    <= tl_next;
            prior_reg <= prior_next;
            ph0_reg   <= ph0_next;
            ph1_reg   <= ph1_next;
            pl0_reg   <= pl0_next;
            pl1_reg   <= pl1_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/parabolic_sar_tracker_top.sv =====
// Top level of the parabolic stop-and-reverse tracker: input register,
// tracker core, result register and configuration port.
// Depends on pst_pkg, pst_bar_if, pst_level_if, pst_regs and pst_core.
//
// Price bars arrive oldest first on the bar channel, one per transfer, and
// each bar gives exactly one result on the level channel: the bar's
// stop-and-reverse level, whether a direction has been established, and
// the trend after the bar. A bar with restart set begins a new series.
// A bar is taken into the input register on its transfer, runs through the
// core once the result register is free and lands in the result register,
// where its result is offered. The block takes one bar every cycle while
// the receiver keeps up; the figure is set by the core's combinational state
// update, with one 32 by 16 multiply and the clamp and reversal compares.
// When the receiver stalls, the waiting result holds and one more bar is
// still taken into the input register before ready drops.
// Reset clears the tracker state and both pipeline stages and loads the
// step and limit registers with their defaults. The user must write step
// and limit over APB only while no bar is in flight; the block does not enforce it.
`default_nettype none

module parabolic_sar_tracker_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    pst_bar_if.sink                            bar,
    pst_level_if.source                        level,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pst_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [pst_pkg::DATA_BITS-1:0] pwdata,
    output logic      [pst_pkg::DATA_BITS-1:0] prdata,
    output logic                               pready
);
    import pst_pkg::*;

    cfg_t   cfg;
    logic   s1_valid_reg;
    bar_t   s1_item_reg;
    logic   out_valid_reg;
    level_t out_reg;
    level_t result;
    logic   out_free;
    logic   fire;
    logic   bar_take;

    assign out_free  = !out_valid_reg || level.ready;
    assign fire      = s1_valid_reg && out_free;
    assign bar.ready = !s1_valid_reg || fire;
    assign bar_take  = bar.valid && bar.ready;

    pst_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pst_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (fire),
        .item   (s1_item_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (bar_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bar_take)
        begin
            s1_item_reg.bar_high <= bar.bar_high;
            s1_item_reg.bar_low  <= bar.bar_low;
            s1_item_reg.restart  <= bar.restart;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (level.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= result;
        end
    end

    assign level.valid       = out_valid_reg;
    assign level.sar_level   = out_reg.sar_level;
    assign level.level_valid = out_reg.level_valid;
    assign level.going_long  = out_reg.going_long;

    // A bar waiting in the input register moves on whenever the result slot frees.
    a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_free |=> out_valid_reg)
        else $error("input bar did not reach the result register");

    // A restart bar is the first of its series and never carries a level.
    a_restart_no_level: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_item_reg.restart |=> !out_reg.level_valid)
        else $error("restart bar produced a valid level");

    // A result only appears after a bar was processed.
    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a bar");

endmodule

`default_nettype wire
